/* sv/rrts_pkg.sv */
// Package: shared types and constants of the round-robin thread scheduler.
package rrts_pkg;

	localparam int MaxThreads = 16;
	localparam int TidW       = $clog2(MaxThreads);
	localparam int CntW       = TidW + 1;
	localparam int ValW       = 64;
	localparam int TickW      = 32;
	localparam int QDepth     = 2;

	typedef enum logic [2:0] {
		REQ_TICK    = 3'd0,
		REQ_YIELD   = 3'd1,
		REQ_CREATE  = 3'd2,
		REQ_BLOCK   = 3'd3,
		REQ_UNBLOCK = 3'd4,
		REQ_EXIT    = 3'd5,
		REQ_JOIN    = 3'd6,
		REQ_DETACH  = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		ST_FREE   = 3'd0,
		ST_READY  = 3'd1,
		ST_RUN    = 3'd2,
		ST_BLOCK  = 3'd3,
		ST_ZOMBIE = 3'd4
	} slot_st_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_REFUSED = 2'd1,
		STAT_NOSLOT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]      req_type;
		logic [TidW-1:0] target_tid;
		logic [ValW-1:0] exit_value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [TidW-1:0]  new_tid;
		logic [TidW-1:0]  running_tid;
		logic             switched;
		logic             join_done;
		logic [TidW-1:0]  join_waiter;
		logic [ValW-1:0]  join_value;
		logic [TickW-1:0] tick_total;
	} rsp_word_t;

	// Decoded request that crosses from the front end to the back end.
	typedef struct packed {
		req_t            req;
		logic [TidW-1:0] tgt;
		logic [ValW-1:0] val;
	} cmd_t;

endpackage

/* sv/rrts_if.sv */
// Interface: valid/ready channel carrying one request or response word.
interface rrts_req_if import rrts_pkg::*; (input logic clk);
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; (input logic clk);
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/rrts_front.sv */
// Front end: accept request words, decode them and queue them for the back end.
module rrts_front import rrts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rrts_req_if.sink     req,
	output logic         cmd_valid,
	output cmd_t         cmd,
	input  logic         cmd_take
);
	localparam int PW = $clog2(QDepth);

	cmd_t              q_mem [QDepth];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       cnt_q;
	logic              push;
	cmd_t              dec;

	always_comb begin
		dec.req = req_t'(req.data.req_type);
		dec.tgt = req.data.target_tid;
		dec.val = req.data.exit_value;
	end

	assign req.ready = (cnt_q != (PW+1)'(QDepth));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(cmd_take);
		end
	end
endmodule

/* sv/rrts_back.sv */
// Back end: carry out one scheduling event over the slot table and ready queue.
module rrts_back import rrts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	input  cmd_t         cmd,
	output logic         cmd_take,
	rrts_rsp_if.source   rsp
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SCHED = 4'b0100,
		S_DONE  = 4'b1000
	} fsm_t;

	fsm_t                 fsm_q;
	slot_st_t             st_q   [MaxThreads];
	logic [MaxThreads-1:0] det_q;
	logic [TidW:0]        wt_q   [MaxThreads];
	logic [ValW-1:0]      val_mem [MaxThreads];
	logic [TidW-1:0]      fifo_mem [MaxThreads];
	logic [TidW-1:0]      head_q;
	logic [CntW-1:0]      cnt_q;
	logic [TidW-1:0]      run_q;
	logic [TickW-1:0]     tick_q;
	cmd_t                 cmd_q;
	logic [TidW-1:0]      before_q;
	rsp_word_t            out_q;
	logic                 out_v_q;
	logic [ValW-1:0]      val_rd_q;
	logic [TidW-1:0]      head_rd_q;
	// Waiter pushed into an empty queue by an exit: it is the new head, which
	// the registered head read has not seen yet.
	logic                 wake_v_q;
	logic [TidW-1:0]      wake_tid_q;

	// Combinational view of the free slot search.
	logic                 found;
	logic [TidW-1:0]      free_idx;
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = MaxThreads - 1; i >= 1; i--) begin
			if (st_q[i] == ST_FREE) begin
				found    = 1'b1;
				free_idx = TidW'(i);
			end
		end
	end

	assign cmd_take  = (fsm_q == S_IDLE) && cmd_valid && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// Registered reads of the value store and queue.
	always_ff @(posedge clk) begin
		val_rd_q  <= val_mem[cmd.tgt];
		head_rd_q <= fifo_mem[head_q];
	end

	logic            tgt_ok;
	logic [TidW-1:0] cur;
	assign cur    = run_q;
	assign tgt_ok = (st_q[cmd_q.tgt] != ST_FREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= S_IDLE;
			for (int i = 0; i < MaxThreads; i++) begin
				st_q[i] <= ST_FREE;
				wt_q[i] <= '0;
			end
			st_q[0] <= ST_READY;
			st_q[1] <= ST_RUN;
			det_q   <= MaxThreads'(2'b11);
			head_q  <= '0;
			cnt_q   <= '0;
			run_q   <= TidW'(1);
			tick_q  <= '0;
			out_v_q <= 1'b0;
			wake_v_q   <= 1'b0;
			wake_tid_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (cmd_take) begin
						cmd_q    <= cmd;
						before_q <= run_q;
						fsm_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					out_q              <= '0;
					out_q.tick_total   <= tick_q;
					wake_v_q           <= 1'b0;
					fsm_q              <= S_DONE;
					unique case (cmd_q.req)
						REQ_TICK: begin
							tick_q           <= tick_q + 1'b1;
							out_q.tick_total <= tick_q + 1'b1;
							fsm_q            <= S_SCHED;
						end
						REQ_YIELD: begin
							fsm_q        <= S_SCHED;
						end
						REQ_CREATE: begin
							if (found) begin
								det_q[free_idx] <= 1'b0;
								wt_q[free_idx]  <= '0;
								val_mem[free_idx] <= '0;
								st_q[free_idx]  <= ST_READY;
								fifo_mem[head_q + cnt_q[TidW-1:0]] <= free_idx;
								cnt_q           <= cnt_q + 1'b1;
								out_q.new_tid   <= free_idx;
							end else begin
								out_q.status <= STAT_NOSLOT;
							end
						end
						REQ_BLOCK: begin
							if (cur == '0) begin
								out_q.status <= STAT_REFUSED;
							end else begin
								st_q[cur]    <= ST_BLOCK;
								fsm_q        <= S_SCHED;
							end
						end
						REQ_UNBLOCK: begin
							if (!tgt_ok || st_q[cmd_q.tgt] != ST_BLOCK) begin
								out_q.status <= STAT_REFUSED;
							end else begin
								st_q[cmd_q.tgt] <= ST_READY;
								fifo_mem[head_q + cnt_q[TidW-1:0]] <= cmd_q.tgt;
								cnt_q <= cnt_q + 1'b1;
							end
						end
						REQ_EXIT: begin
							if (cur == '0) begin
								out_q.status <= STAT_REFUSED;
							end else begin
								// Drop marks naming the exiting slot, including its own.
								for (int i = 0; i < MaxThreads; i++) begin
									if (wt_q[i] == {1'b0, cur} + 1'b1) begin
										wt_q[i] <= '0;
									end
								end
								if (wt_q[cur] != '0 &&
									wt_q[cur] != {1'b0, cur} + 1'b1) begin
									out_q.join_done   <= 1'b1;
									out_q.join_waiter <= TidW'(wt_q[cur] - 1'b1);
									out_q.join_value  <= cmd_q.val;
									st_q[cur]  <= ST_FREE;
									det_q[cur] <= 1'b0;
									wt_q[cur]  <= '0;
									val_mem[cur] <= '0;
									if (st_q[TidW'(wt_q[cur] - 1'b1)] == ST_BLOCK) begin
										st_q[TidW'(wt_q[cur] - 1'b1)] <= ST_READY;
										fifo_mem[head_q + cnt_q[TidW-1:0]] <=
											TidW'(wt_q[cur] - 1'b1);
										cnt_q      <= cnt_q + 1'b1;
										wake_v_q   <= (cnt_q == '0);
										wake_tid_q <= TidW'(wt_q[cur] - 1'b1);
									end
								end else if (det_q[cur]) begin
									st_q[cur]  <= ST_FREE;
									det_q[cur] <= 1'b0;
									wt_q[cur]  <= '0;
									val_mem[cur] <= '0;
								end else begin
									st_q[cur]    <= ST_ZOMBIE;
									val_mem[cur] <= cmd_q.val;
								end
								fsm_q        <= S_SCHED;
							end
						end
						REQ_JOIN: begin
							if (cur == '0 || !tgt_ok || cmd_q.tgt == cur ||
								det_q[cmd_q.tgt] || wt_q[cmd_q.tgt] != '0) begin
								out_q.status <= STAT_REFUSED;
							end else if (st_q[cmd_q.tgt] == ST_ZOMBIE) begin
								out_q.join_done   <= 1'b1;
								out_q.join_waiter <= cur;
								out_q.join_value  <= val_rd_q;
								st_q[cmd_q.tgt]  <= ST_FREE;
								det_q[cmd_q.tgt] <= 1'b0;
								val_mem[cmd_q.tgt] <= '0;
								for (int i = 0; i < MaxThreads; i++) begin
									if (wt_q[i] == {1'b0, cmd_q.tgt} + 1'b1) begin
										wt_q[i] <= '0;
									end
								end
								wt_q[cmd_q.tgt] <= '0;
							end else begin
								wt_q[cmd_q.tgt] <= {1'b0, cur} + 1'b1;
								st_q[cur]       <= ST_BLOCK;
								fsm_q           <= S_SCHED;
							end
						end
						REQ_DETACH: begin
							if (!tgt_ok) begin
								out_q.status <= STAT_REFUSED;
							end else if (st_q[cmd_q.tgt] == ST_ZOMBIE) begin
								st_q[cmd_q.tgt]  <= ST_FREE;
								det_q[cmd_q.tgt] <= 1'b0;
								val_mem[cmd_q.tgt] <= '0;
								for (int i = 0; i < MaxThreads; i++) begin
									if (wt_q[i] == {1'b0, cmd_q.tgt} + 1'b1) begin
										wt_q[i] <= '0;
									end
								end
								wt_q[cmd_q.tgt] <= '0;
							end else begin
								det_q[cmd_q.tgt] <= 1'b1;
							end
						end
						default: begin
							out_q.status <= STAT_REFUSED;
						end
					endcase
				end
				S_SCHED: begin
					// Requeue a still-running thread; pop the head or fall to idle.
					logic [TidW-1:0] nxt;
					logic [CntW-1:0] c;
					logic [TidW-1:0] h;
					c = cnt_q;
					h = head_q;
					nxt = '0;
					if (run_q != '0 && st_q[run_q] == ST_RUN) begin
						st_q[run_q] <= ST_READY;
						fifo_mem[h + c[TidW-1:0]] <= run_q;
						c = c + 1'b1;
					end
					if (c != '0) begin
						if (cnt_q == '0) begin
							nxt = run_q;
						end else if (wake_v_q) begin
							nxt = wake_tid_q;
						end else begin
							nxt = head_rd_q;
						end
						h   = h + 1'b1;
						c   = c - 1'b1;
					end
					if (run_q == '0 && nxt != '0) begin
						st_q[0] <= ST_READY;
					end
					st_q[nxt]         <= ST_RUN;
					run_q             <= nxt;
					head_q            <= h;
					cnt_q             <= c;
					out_q.running_tid <= nxt;
					out_q.switched    <= (nxt != before_q);
					fsm_q             <= S_IDLE;
					out_v_q           <= 1'b1;
				end
				S_DONE: begin
					out_q.running_tid <= run_q;
					out_q.switched    <= 1'b0;
					fsm_q             <= S_IDLE;
					out_v_q           <= 1'b1;
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/round_robin_thread_scheduler.sv */
// Top level: round-robin thread scheduler with join.
//
// Usage
//   req : one word per scheduling event (req_type, target_tid, exit_value),
//         accepted when valid and ready are high at a rising edge of clk.
//   rsp : one word per event, in order: status, new_tid, running_tid,
//         switched, join_done, join_waiter, join_value, tick_total.
// Path: a request waits in the front queue, is taken and executed by the
//   back end, then is rescheduled or settles into the output register.
// Events pass one at a time through the back-end sequencer that owns the
//   slot table and ready queue (take, execute, settle, then hand over the
//   response word before the next event is taken).
// A two-word queue sits between the decoding front end and the back end,
//   so requests keep being taken while a response waits.
// Reset (arst_n low): slot 0 is the ready idle thread, slot 1 runs, all
//   other slots are free, the ready queue is empty and the tick count is 0.
// When the receiver stalls, the response word holds and the back end takes
//   no new event; the front queue fills and then drops req.ready.
module round_robin_thread_scheduler import rrts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rrts_req_if.sink  req,
	rrts_rsp_if.source rsp
);
	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	// Accept and decode words.
	rrts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	// Execute events against the slot table.
	rrts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.rsp      (rsp)
	);
endmodule

/* sv/rrts_checker.sv */
// Checker: port-level properties of the thread scheduler, bound to the top.
module rrts_port_checker import rrts_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped while stalled");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid)
		else $error("request withdrawn before acceptance");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status != 2'd3)
		else $error("bad status code");

	a_join_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.join_done |-> rsp_data.status == STAT_OK)
		else $error("join done with error status");

	a_new_tid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.new_tid != '0 |-> rsp_data.status == STAT_OK &&
		!rsp_data.switched)
		else $error("create result inconsistent");
endmodule

bind round_robin_thread_scheduler rrts_port_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

/* tb/rrts_checker.sv */
// Checker: predicts each response word of the scheduler and compares it with the one seen.
module rrts_checker import rrts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rrts_req_if  req,
	rrts_rsp_if  rsp,
	output int   errors,
	output int   pending
);

	slot_st_t          st    [MaxThreads];
	logic              det   [MaxThreads];
	logic [4:0]        wtr   [MaxThreads];
	logic [ValW-1:0]   xval  [MaxThreads];
	logic [TidW-1:0]   rq    [MaxThreads];
	logic [TidW-1:0]   rq_head;
	logic [CntW-1:0]   rq_count;
	logic [TidW-1:0]   cur_tid;
	logic [TickW-1:0]  ticks;
	rsp_word_t         expected_rsp[$];

	// Mark a slot ready and append it to the run queue.
	function automatic void enqueue(logic [TidW-1:0] s);
		st[s] = ST_READY;
		if (rq_count < MaxThreads) begin
			rq[rq_head + rq_count[TidW-1:0]] = s;
			rq_count++;
		end
	endfunction

	function automatic void clear_waits(logic [TidW-1:0] s);
		for (int i = 0; i < MaxThreads; i++)
			if (wtr[i] == {1'b0, s} + 5'd1)
				wtr[i] = '0;
	endfunction

	function automatic void release_slot(logic [TidW-1:0] s);
		st[s]   = ST_FREE;
		det[s]  = 1'b0;
		wtr[s]  = '0;
		xval[s] = '0;
		clear_waits(s);
	endfunction

	function automatic void pick_next();
		logic [TidW-1:0] prev;
		logic [TidW-1:0] nxt;
		prev = cur_tid;
		nxt  = '0;
		if (prev != 0 && st[prev] == ST_RUN)
			enqueue(prev);
		if (rq_count > 0) begin
			nxt = rq[rq_head];
			rq_head++;
			rq_count--;
		end
		if (prev == 0 && nxt != 0)
			st[0] = ST_READY;
		st[nxt] = ST_RUN;
		cur_tid = nxt;
	endfunction

	function automatic rsp_word_t schedule_event(req_word_t w);
		rsp_word_t       r;
		logic [TidW-1:0] was;
		logic [TidW-1:0] t;
		logic            t_live;
		r       = '0;
		was     = cur_tid;
		t       = w.target_tid;
		t_live  = st[t] != ST_FREE;
		case (req_t'(w.req_type))
			REQ_TICK: begin
				ticks++;
				pick_next();
			end
			REQ_YIELD: pick_next();
			REQ_CREATE: begin
				r.status = STAT_NOSLOT;
				for (int i = 1; i < MaxThreads; i++) begin
					if (r.status == STAT_NOSLOT && st[i] == ST_FREE) begin
						det[i]    = 1'b0;
						wtr[i]    = '0;
						xval[i]   = '0;
						enqueue(i[TidW-1:0]);
						r.new_tid = i[TidW-1:0];
						r.status  = STAT_OK;
					end
				end
			end
			REQ_BLOCK: begin
				if (cur_tid == 0) begin
					r.status = STAT_REFUSED;
				end else begin
					st[cur_tid] = ST_BLOCK;
					pick_next();
				end
			end
			REQ_UNBLOCK: begin
				if (!t_live || st[t] != ST_BLOCK)
					r.status = STAT_REFUSED;
				else
					enqueue(t);
			end
			REQ_EXIT: begin
				if (cur_tid == 0) begin
					r.status = STAT_REFUSED;
				end else begin
					xval[cur_tid] = w.exit_value;
					st[cur_tid]   = ST_ZOMBIE;
					clear_waits(cur_tid);
					if (wtr[cur_tid] != 0) begin
						r.join_waiter = wtr[cur_tid][TidW-1:0] - 1'b1;
						r.join_done   = 1'b1;
						r.join_value  = w.exit_value;
						release_slot(cur_tid);
						if (st[r.join_waiter] == ST_BLOCK)
							enqueue(r.join_waiter);
					end else if (det[cur_tid]) begin
						release_slot(cur_tid);
					end
					pick_next();
				end
			end
			REQ_JOIN: begin
				if (cur_tid == 0 || !t_live || t == cur_tid || det[t] || wtr[t] != 0) begin
					r.status = STAT_REFUSED;
				end else if (st[t] == ST_ZOMBIE) begin
					r.join_done   = 1'b1;
					r.join_waiter = cur_tid;
					r.join_value  = xval[t];
					release_slot(t);
				end else begin
					wtr[t]      = {1'b0, cur_tid} + 5'd1;
					st[cur_tid] = ST_BLOCK;
					pick_next();
				end
			end
			default: begin
				if (!t_live) begin
					r.status = STAT_REFUSED;
				end else begin
					det[t] = 1'b1;
					if (st[t] == ST_ZOMBIE)
						release_slot(t);
				end
			end
		endcase
		r.running_tid = cur_tid;
		r.switched    = cur_tid != was;
		r.tick_total  = ticks;
		return r;
	endfunction

	initial begin
		for (int i = 0; i < MaxThreads; i++) begin
			st[i]   = ST_FREE;
			det[i]  = 1'b0;
			wtr[i]  = '0;
			xval[i] = '0;
			rq[i]   = '0;
		end
		st[0]    = ST_READY;
		st[1]    = ST_RUN;
		det[0]   = 1'b1;
		det[1]   = 1'b1;
		rq_head  = '0;
		rq_count = '0;
		cur_tid  = 1;
		ticks    = '0;
		errors   = 0;
		pending  = 0;
	end

	// Sample between edges: inputs move only at rising edges, so the negedge value is
	// the one the next rising edge sees.
	always @(negedge clk) begin
		rsp_word_t e;
		rsp_word_t g;
		logic      bad;
		if (arst_n && req.valid && req.ready)
			expected_rsp.push_back(schedule_event(req.data));
		if (arst_n && rsp.valid && rsp.ready) begin
			g = rsp.data;
			if (expected_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response word %h", g);
			end else begin
				e = expected_rsp.pop_front();
				bad = g.status != e.status || g.new_tid != e.new_tid
					|| g.running_tid != e.running_tid || g.switched != e.switched
					|| g.join_done != e.join_done || g.join_waiter != e.join_waiter
					|| g.join_value != e.join_value || g.tick_total != e.tick_total;
				if (bad) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st=%0d new=%0d run=%0d sw=%0d jd=%0d jw=%0d jv=%h tk=%0d, got st=%0d new=%0d run=%0d sw=%0d jd=%0d jw=%0d jv=%h tk=%0d",
							e.status, e.new_tid, e.running_tid, e.switched, e.join_done,
							e.join_waiter, e.join_value, e.tick_total,
							g.status, g.new_tid, g.running_tid, g.switched, g.join_done,
							g.join_waiter, g.join_value, g.tick_total);
				end
			end
		end
		pending = expected_rsp.size();
	end

endmodule

/* tb/tb_round_robin_thread_scheduler.sv */
// Testbench top: drives scheduling events into the scheduler and gives the verdict.
module tb_round_robin_thread_scheduler;
	import rrts_pkg::*;

	logic clk;
	logic arst_n;
	logic calm;
	int   errors;
	int   pending;

	rrts_req_if req (clk);
	rrts_rsp_if rsp (clk);

	round_robin_thread_scheduler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	rrts_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Stall the receiver at random, holding each choice for a random stretch.
	initial begin
		int hold;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			hold = pick_gap();
			if (hold == 0) begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b0;
				repeat (hold - 1) @(posedge clk);
			end
		end
	end

	// Present one word after an optional gap and hold it until accepted. Call at a
	// rising edge; return at the edge that takes the word.
	task automatic send_word(req_t op, logic [TidW-1:0] tgt, logic [ValW-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid           <= 1'b1;
		req.data.req_type   <= op;
		req.data.target_tid <= tgt;
		req.data.exit_value <= val;
		do @(negedge clk); while (!req.ready);
		@(posedge clk);
	endtask

	function automatic logic [ValW-1:0] rand_val();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t rand_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18) return REQ_CREATE;
		if (r < 28) return REQ_TICK;
		if (r < 38) return REQ_YIELD;
		if (r < 48) return REQ_BLOCK;
		if (r < 63) return REQ_UNBLOCK;
		if (r < 75) return REQ_EXIT;
		if (r < 90) return REQ_JOIN;
		return REQ_DETACH;
	endfunction

	initial begin
		calm     = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: refusals (unblock of the ready idle thread, detach of a free slot).
		send_word(REQ_UNBLOCK, 4'd0, '0);
		send_word(REQ_DETACH, 4'd9, '0);
		// Fill the table; the last create finds no free slot.
		for (int i = 0; i < 15; i++)
			send_word(REQ_CREATE, '0, '0);
		send_word(REQ_JOIN, 4'd2, '0);
		send_word(REQ_EXIT, '0, '1);
		send_word(REQ_YIELD, '0, '0);
		send_word(REQ_EXIT, '0, 64'h0);
		send_word(REQ_JOIN, 4'd1, '0);
		send_word(REQ_DETACH, 4'd15, '0);
		send_word(REQ_BLOCK, '0, '0);
		send_word(REQ_UNBLOCK, 4'd15, '0);
		send_word(REQ_TICK, '0, '0);

		// Random: mostly targets from the low slots, some anywhere.
		for (int n = 0; n < 1050; n++) begin
			calm = n >= 400 && n < 520;
			send_word(rand_op(),
				($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7)),
				rand_val());
		end
		req.valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_round_robin_thread_scheduler: done, clean");
		else
			$display("tb_round_robin_thread_scheduler: done, errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_round_robin_thread_scheduler: done, errors");
		$finish;
	end

endmodule

/* sim.f */
sv/rrts_pkg.sv
sv/rrts_if.sv
sv/rrts_front.sv
sv/rrts_back.sv
sv/round_robin_thread_scheduler.sv
sv/rrts_checker.sv
tb/rrts_checker.sv
tb/tb_round_robin_thread_scheduler.sv
